// File: src/assert_macros.svh
// Assertion macros used by the port-level checker of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ple_pkg.sv
// Types and codes shared by the positional list engine and its cells.
`default_nettype none

package ple_pkg;

    localparam logic [2:0] OP_APPEND   = 3'd0;
    localparam logic [2:0] OP_INSERT   = 3'd1;
    localparam logic [2:0] OP_REMOVE   = 3'd2;
    localparam logic [2:0] OP_GET      = 3'd3;
    localparam logic [2:0] OP_SET      = 3'd4;
    localparam logic [2:0] OP_POP_AT   = 3'd5;
    localparam logic [2:0] OP_POP_LAST = 3'd6;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_RANGE = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;
    localparam logic [1:0] STS_EMPTY = 2'd3;

    // What every cell does with its entry at each clock edge.
    localparam logic [1:0] CM_HOLD  = 2'd0;
    localparam logic [1:0] CM_SET   = 2'd1;
    localparam logic [1:0] CM_OPEN  = 2'd2;
    localparam logic [1:0] CM_CLOSE = 2'd3;

    localparam int INDEX_W = 7;
    localparam int LEN_W   = 7;
    localparam int WORD_W  = 32;

    typedef struct packed {
        logic [2:0]                operation;
        logic [INDEX_W-1:0]        index;
        logic signed [WORD_W-1:0]  value;
    } t_in;

    typedef struct packed {
        logic signed [WORD_W-1:0]  read_value;
        logic [LEN_W-1:0]          length;
        logic [1:0]                status;
    } t_out;

    typedef struct packed {
        logic [1:0]          mode;
        logic [WORD_W-1:0]   value;
    } t_cell_cmd;

endpackage

`default_nettype wire

// File: src/ple_cell.sv
// One cell of the list chain: holds one entry and passes read data upward.
`default_nettype none

module ple_cell #(
    parameter int POS_W = 6,
    parameter int IDX   = 0
) (
    input  wire logic                      i_clk,
    input  wire ple_pkg::t_cell_cmd        i_cmd,
    input  wire logic [POS_W-1:0]          i_pos,
    input  wire logic [ple_pkg::WORD_W-1:0] i_lower,
    input  wire logic [ple_pkg::WORD_W-1:0] i_upper,
    input  wire logic [ple_pkg::WORD_W-1:0] i_rd,
    output logic [ple_pkg::WORD_W-1:0]      o_entry,
    output logic [ple_pkg::WORD_W-1:0]      o_rd
);
    import ple_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

    logic [WORD_W-1:0] r_entry;
    logic [WORD_W-1:0] n_entry;
    logic [WORD_W-1:0] r_rd;
    logic              w_hit;
    logic              w_above;

    assign w_hit   = (MY_POS == i_pos);
    assign w_above = (MY_POS > i_pos);

    always_comb begin
        n_entry = r_entry;
        unique case (i_cmd.mode)
            CM_HOLD: begin
                n_entry = r_entry;
            end
            CM_SET: begin
                if (w_hit) n_entry = i_cmd.value;
            end
            CM_OPEN: begin
                if (w_above)    n_entry = i_lower;
                else if (w_hit) n_entry = i_cmd.value;
            end
            CM_CLOSE: begin
                if (w_hit || w_above) n_entry = i_upper;
            end
        endcase
    end

    // The read word enters the chain at the addressed cell and rides up to the top.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_rd    <= w_hit ? r_entry : i_rd;
    end

    assign o_entry = r_entry;
    assign o_rd    = r_rd;

endmodule

`default_nettype wire

// File: src/positional_list_engine.sv
// Top level of the positional list engine: request decode, control and the cell chain.
//
// Usage: requests arrive on the input channel (i_in_valid, o_in_ready, i_in) and
// one result item per request leaves on the output channel (o_out_valid,
// i_out_ready, o_out). Both channels follow a valid/ready handshake.
// The list lives in a chain of CAPACITY cells; a shift for insert, remove or
// pop at index moves every entry at or above the addressed position by one
// position, all in the same cycle. A request that reads no word (append,
// insert, remove, set, refused requests) goes from idle straight to the apply
// step, which registers its result. Get, pop at index and pop last first pass
// through the read step, in which the read path carries the word up through the
// chain one cell per cycle, and then through the apply step.
// One request is in work at a time; the next is accepted as soon as the block
// is back in idle, even while the previous result still waits in the output
// register. If the receiver stalls, the result holds and the following request
// waits in its final step until the output register frees.
// Reset clears the length to zero and drops any pending result; entries are
// left as they are and are never read before being written.
`default_nettype none

module positional_list_engine #(
    parameter int CAPACITY = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire ple_pkg::t_in    i_in,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output ple_pkg::t_out        o_out
);
    import ple_pkg::*;

    localparam int POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [POS_W-1:0] LAST_CYC = POS_W'(CAPACITY - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]        r_state;
    logic [CNT_W-1:0]  r_count;
    logic [POS_W-1:0]  r_cyc;

    logic [1:0]        r_mode;
    logic [POS_W-1:0]  r_pos;
    logic [WORD_W-1:0] r_value;
    logic [1:0]        r_status;
    logic [CNT_W-1:0]  r_newcount;
    logic              r_read;

    logic              r_out_valid;
    t_out              r_out;

    logic [1:0]        n_mode;
    logic [CMP_W-1:0]  n_pos_ext;
    logic [1:0]        n_status;
    logic [CNT_W-1:0]  n_newcount;
    logic              n_read;

    logic [CMP_W-1:0]  w_idx;
    logic [CMP_W-1:0]  w_cnt;
    logic [CMP_W-1:0]  w_cnt_m1;
    logic              w_full;
    logic              w_accept;
    logic              w_apply;
    logic [CMP_W-1:0]  w_len_ext;
    t_cell_cmd         w_cmd;

    logic [WORD_W-1:0] w_entry [CAPACITY];
    logic [WORD_W-1:0] w_rd    [CAPACITY];

    assign w_idx    = CMP_W'(i_in.index);
    assign w_cnt    = CMP_W'(r_count);
    assign w_cnt_m1 = w_cnt - CMP_W'(1);
    assign w_full   = (r_count == CAP_CNT);

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_apply    = (r_state == S_APPLY) && (!r_out_valid || i_out_ready);

    // Request decode: status, new length and the cell action, from the current length.
    always_comb begin
        n_mode     = CM_HOLD;
        n_pos_ext  = w_idx;
        n_status   = STS_OK;
        n_newcount = r_count;
        n_read     = 1'b0;
        unique case (i_in.operation)
            OP_APPEND: begin
                if (w_full) begin
                    n_status = STS_FULL;
                end else begin
                    n_mode     = CM_SET;
                    n_pos_ext  = w_cnt;
                    n_newcount = r_count + CNT_W'(1);
                end
            end
            OP_INSERT: begin
                if (w_full) begin
                    n_status = STS_FULL;
                end else if (w_idx > w_cnt) begin
                    n_status = STS_RANGE;
                end else begin
                    n_mode     = CM_OPEN;
                    n_newcount = r_count + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (w_idx >= w_cnt) begin
                    n_status = STS_RANGE;
                end else begin
                    n_mode     = CM_CLOSE;
                    n_newcount = r_count - CNT_W'(1);
                end
            end
            OP_GET: begin
                if (w_idx >= w_cnt) n_status = STS_RANGE;
                else                n_read   = 1'b1;
            end
            OP_SET: begin
                if (w_idx >= w_cnt) n_status = STS_RANGE;
                else                n_mode   = CM_SET;
            end
            OP_POP_AT: begin
                if (w_idx >= w_cnt) begin
                    n_status = STS_RANGE;
                end else begin
                    n_mode     = CM_CLOSE;
                    n_read     = 1'b1;
                    n_newcount = r_count - CNT_W'(1);
                end
            end
            OP_POP_LAST: begin
                if (r_count == '0) begin
                    n_status = STS_EMPTY;
                end else begin
                    n_pos_ext  = w_cnt_m1;
                    n_read     = 1'b1;
                    n_newcount = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_mode = CM_HOLD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cyc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !w_apply) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cyc   <= '0;
                        r_state <= n_read ? S_READ : S_APPLY;
                    end
                end
                S_READ: begin
                    r_cyc <= r_cyc + POS_W'(1);
                    if (r_cyc == LAST_CYC) r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (w_apply) begin
                        r_count     <= r_newcount;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign w_len_ext = CMP_W'(r_newcount);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode     <= n_mode;
            r_pos      <= n_pos_ext[POS_W-1:0];
            r_value    <= i_in.value;
            r_status   <= n_status;
            r_newcount <= n_newcount;
            r_read     <= n_read;
        end
        if (w_apply) begin
            r_out.read_value <= r_read ? w_rd[CAPACITY-1] : '0;
            r_out.length     <= w_len_ext[LEN_W-1:0];
            r_out.status     <= r_status;
        end
    end

    // Cells change only in the cycle the result is registered; reads finish before that.
    assign w_cmd.mode  = w_apply ? r_mode : CM_HOLD;
    assign w_cmd.value = r_value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_W-1:0] w_lower;
        logic [WORD_W-1:0] w_upper;
        logic [WORD_W-1:0] w_rd_in;

        if (g == 0) begin : g_first
            assign w_lower = '0;
            assign w_rd_in = '0;
        end else begin : g_mid
            assign w_lower = w_entry[g-1];
            assign w_rd_in = w_rd[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_upper = '0;
        end else begin : g_next
            assign w_upper = w_entry[g+1];
        end

        ple_cell #(
            .POS_W (POS_W),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_pos   (r_pos),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .i_rd    (w_rd_in),
            .o_entry (w_entry[g]),
            .o_rd    (w_rd[g])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// File: src/ple_checker.sv
// Port-level checker for the positional list engine, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module ple_checker #(
    parameter int CAPACITY = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_in_ready,
    input  wire ple_pkg::t_in    i_in,
    input  wire logic            i_out_valid,
    input  wire logic            i_out_ready,
    input  wire ple_pkg::t_out   i_out
);
    import ple_pkg::*;

    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    // A request item that waits for the block must hold.
    `ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && !i_in_ready,
        i_in_valid && $stable(i_in), "request changed while waiting")

    // A stalled result item must hold.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out), "result changed while stalled")

    // A refused append or insert reports a full list.
    `ASSERT_IMPL(a_full_len, i_clk, i_rst_n, i_out_valid && (i_out.status == STS_FULL),
        (i_out.length == CAP_LEN) && (i_out.read_value == '0), "full status with wrong length")

    // A refused pop last reports an empty list and no word.
    `ASSERT_IMPL(a_empty_len, i_clk, i_rst_n, i_out_valid && (i_out.status == STS_EMPTY),
        (i_out.length == '0) && (i_out.read_value == '0), "empty status with data")

    // An index refusal never returns a word.
    `ASSERT_IMPL(a_range_zero, i_clk, i_rst_n, i_out_valid && (i_out.status == STS_RANGE),
        i_out.read_value == '0, "range status with data")

endmodule

bind positional_list_engine ple_checker #(
    .CAPACITY (CAPACITY)
) u_ple_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in        (i_in),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out       (o_out)
);

`default_nettype wire

// File: tb/ple_list_checker.sv
// Checker for the positional list engine: predicts each result item and compares it.
`timescale 1ns / 100ps

module ple_list_checker #(
    parameter int CAPACITY = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  ple_pkg::t_in  i_in,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  ple_pkg::t_out i_out,
    output int            o_fail_count,
    output int            o_pending
);
    import ple_pkg::*;

    localparam int MAX_PRINTED = 40;

    logic [WORD_W-1:0] list_words [CAPACITY];
    int unsigned       list_size;
    t_out              expected_results [$];
    int                errors;
    int                results_seen;
    t_out              want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        errors       = 0;
        results_seen = 0;
        list_size    = 0;
    end

    // Applies one request to the shadow list and returns the result item it must produce.
    function automatic t_out apply_request(input t_in req);
        t_out        res;
        int unsigned pos;
        int unsigned i;
        res.read_value = '0;
        res.status     = STS_OK;
        pos            = req.index;
        case (req.operation)
            OP_APPEND: begin
                if (list_size >= CAPACITY) begin
                    res.status = STS_FULL;
                end else begin
                    list_words[list_size] = req.value;
                    list_size++;
                end
            end
            OP_INSERT: begin
                // A full list is refused before the index is looked at.
                if (list_size >= CAPACITY) begin
                    res.status = STS_FULL;
                end else if (pos > list_size) begin
                    res.status = STS_RANGE;
                end else begin
                    for (i = list_size; i > pos; i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos] = req.value;
                    list_size++;
                end
            end
            OP_REMOVE, OP_POP_AT: begin
                if (pos >= list_size) begin
                    res.status = STS_RANGE;
                end else begin
                    if (req.operation == OP_POP_AT)
                        res.read_value = list_words[pos];
                    for (i = pos; i + 1 < list_size; i++)
                        list_words[i] = list_words[i+1];
                    list_size--;
                end
            end
            OP_GET: begin
                if (pos >= list_size)
                    res.status = STS_RANGE;
                else
                    res.read_value = list_words[pos];
            end
            OP_SET: begin
                if (pos >= list_size)
                    res.status = STS_RANGE;
                else
                    list_words[pos] = req.value;
            end
            OP_POP_LAST: begin
                if (list_size == 0) begin
                    res.status = STS_EMPTY;
                end else begin
                    res.read_value = list_words[list_size-1];
                    list_size--;
                end
            end
            default: begin
            end
        endcase
        res.length = LEN_W'(list_size);
        return res;
    endfunction

    task automatic report_error(input string msg);
        if (errors < MAX_PRINTED)
            $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_size = 0;
            expected_results.delete();
        end else begin
            // A result item always belongs to an older request than one taken at the same edge.
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_error($sformatf("result %0d arrived with no request waiting",
                                           results_seen));
                end else begin
                    want = expected_results.pop_front();
                    if (i_out.read_value !== want.read_value)
                        report_error($sformatf("result %0d read_value %0d, expected %0d",
                                               results_seen, i_out.read_value,
                                               want.read_value));
                    if (i_out.length !== want.length)
                        report_error($sformatf("result %0d length %0d, expected %0d",
                                               results_seen, i_out.length, want.length));
                    if (i_out.status !== want.status)
                        report_error($sformatf("result %0d status %0d, expected %0d",
                                               results_seen, i_out.status, want.status));
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(apply_request(i_in));
        end
        o_pending    <= expected_results.size();
        o_fail_count <= errors;
    end

endmodule

// File: tb/tb_top.sv
// Testbench top for the positional list engine: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
    import ple_pkg::*;

    localparam int CAPACITY        = 64;
    localparam int MAX_INDEX       = 64;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 80;
    localparam int ITEMS_PER_PHASE = 233;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    logic  i_clk     = 1'b0;
    logic  i_rst_n   = 1'b0;
    logic  in_valid  = 1'b0;
    t_in   in_item   = '0;
    logic  out_ready = 1'b0;
    logic  in_ready;
    logic  out_valid;
    t_out  out_item;

    int    fail_count;
    int    pending;
    int    idle_pct      = 0;
    int    stall_pct     = 0;
    int    hold_requests = 0;
    int    holds_done    = 0;
    int    hold_left     = 0;
    int    quiet_cycles  = 0;
    int    list_len      = 0;
    bit    filling       = 1'b1;
    int    phase;

    always #1 i_clk = ~i_clk;

    positional_list_engine #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    ple_list_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (holds_done != hold_requests) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offers one item, idling first at the current rate, and returns once it is taken.
    task automatic send_item(input logic [2:0] op, input int idx, input logic [31:0] val);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{operation: op, index: INDEX_W'(idx), value: val};
        do @(posedge i_clk); while (!in_ready);
        // Track the length only to steer the random walk between empty and full.
        case (op)
            OP_APPEND:              if (list_len < CAPACITY) list_len++;
            OP_INSERT:              if (list_len < CAPACITY && idx <= list_len) list_len++;
            OP_REMOVE, OP_POP_AT:   if (idx < list_len) list_len--;
            OP_POP_LAST:            if (list_len > 0) list_len--;
            default: begin
            end
        endcase
    endtask

    task automatic send_random(input int n);
        int          k;
        int          r;
        logic [2:0]  op;
        int          idx;
        logic [31:0] val;
        for (k = 0; k < n; k++) begin
            if (filling && list_len == CAPACITY && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (!filling && list_len == 0 && $urandom_range(0, 3) == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 99) == 0)
                filling = !filling;

            r = $urandom_range(0, 99);
            if (filling) begin
                if      (r < 35) op = OP_APPEND;
                else if (r < 65) op = OP_INSERT;
                else if (r < 72) op = OP_REMOVE;
                else if (r < 80) op = OP_GET;
                else if (r < 88) op = OP_SET;
                else if (r < 93) op = OP_POP_AT;
                else if (r < 99) op = OP_POP_LAST;
                else             op = OP_UNUSED;
            end else begin
                if      (r < 8)  op = OP_APPEND;
                else if (r < 16) op = OP_INSERT;
                else if (r < 40) op = OP_REMOVE;
                else if (r < 55) op = OP_GET;
                else if (r < 65) op = OP_SET;
                else if (r < 82) op = OP_POP_AT;
                else if (r < 99) op = OP_POP_LAST;
                else             op = OP_UNUSED;
            end

            // Mostly legal positions; the rest spread from 0 to MAX_INDEX.
            if ($urandom_range(0, 99) < 85) begin
                if (op == OP_INSERT)
                    idx = $urandom_range(0, list_len);
                else
                    idx = (list_len > 0) ? $urandom_range(0, list_len - 1) : 0;
            end else begin
                idx = $urandom_range(0, MAX_INDEX);
            end

            case ($urandom_range(0, 9))
                0:       val = 32'h8000_0000;
                1:       val = 32'h7FFF_FFFF;
                2:       val = 32'hFFFF_FFFF;
                3:       val = 32'h0000_0000;
                default: val = $urandom;
            endcase
            send_item(op, idx, val);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Requests on an empty list.
        send_item(OP_POP_LAST, 0, 32'h1234_5678);
        send_item(OP_GET,      0, 32'h0);
        send_item(OP_REMOVE,   0, 32'h0);
        send_item(OP_POP_AT,   0, 32'h0);
        send_item(OP_SET,      0, 32'h5555_5555);
        send_item(OP_INSERT,   1, 32'hAAAA_AAAA);
        // Build a short list with extreme words at both ends and in the middle.
        send_item(OP_INSERT,   0, 32'h8000_0000);
        send_item(OP_APPEND,   0, 32'h7FFF_FFFF);
        send_item(OP_APPEND,   MAX_INDEX, 32'hFFFF_FFFF);
        send_item(OP_INSERT,   3, 32'h0000_0000);
        send_item(OP_INSERT,   1, 32'h0BAD_CAFE);
        send_item(OP_GET,      0, 32'h0);
        send_item(OP_GET,      4, 32'h0);
        send_item(OP_SET,      2, 32'hDEAD_BEEF);
        send_item(OP_UNUSED,   MAX_INDEX, 32'hFFFF_FFFF);
        send_item(OP_GET,      MAX_INDEX, 32'h0);
        send_item(OP_GET,      5, 32'h0);
        send_item(OP_INSERT,   7, 32'h1111_1111);
        send_item(OP_POP_AT,   1, 32'h0);
        send_item(OP_REMOVE,   0, 32'h0);
        send_item(OP_GET,      1, 32'h0);
        send_item(OP_POP_LAST, 0, 32'h0);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 56; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 56; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            // The sender keeps offering items while the receiver holds off, so the block backs up.
            if (phase == 0 || phase == 3)
                hold_requests++;
            send_random(ITEMS_PER_PHASE);
        end
        in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: positional_list_engine.f
+incdir+src
src/ple_pkg.sv
src/ple_cell.sv
src/positional_list_engine.sv
src/ple_checker.sv
tb/ple_list_checker.sv
tb/tb_top.sv
